### rtl/core/gif_lzw_pkg.sv
package gif_lzw_pkg;

    localparam int CODE_LIMIT    = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int SYMBOL_SPAN   = 256;

    // widest code an emit record can carry
    localparam int CODE_FIELD_W = 12;

    localparam logic [3:0] MIN_BITS_RESET = 4'd8;

    // apb register map, byte address 4*index
    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_MIN_BITS = 1'b0;

    typedef struct packed {
        logic [7:0] symbol;
        logic       image_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       stream_done;
    } t_out_item;

    typedef struct packed {
        logic [CODE_FIELD_W-1:0] code;
        logic [3:0]              width;
    } t_code_slot;

    // codes one index produces, packed lsb first in slot order
    typedef struct packed {
        logic                 start;
        logic                 last;
        t_code_slot [3:0]     slots;
    } t_emit_rec;

endpackage

### rtl/core/gif_lzw_code_stream_encoder_unit.sv
// path: an index in an image leaves the input register at once when idle; its first
// byte passes the child table, back table, record and word registers to o_out_data
// throughput: the dictionary loop (child table read, back table check, write back)
// decides one index as it takes the next; bytes drain one per cycle unless stalled
// reset: synchronous, no clearing pass; entries are checked against the back table
module gif_lzw_code_stream_encoder_unit #(
    parameter int CODE_LIMIT    = gif_lzw_pkg::CODE_LIMIT,
    parameter int MAX_CODE_BITS = gif_lzw_pkg::MAX_CODE_BITS,
    parameter int SYMBOL_SPAN   = gif_lzw_pkg::SYMBOL_SPAN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gif_lzw_pkg::t_in_item             i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gif_lzw_pkg::t_out_item            o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gif_lzw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CODE_W   = $clog2(CODE_LIMIT);
    localparam int SLOTS    = CODE_LIMIT * SYMBOL_SPAN;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int SPAN_LOG = $clog2(SYMBOL_SPAN + 1) - 1;
    localparam logic [3:0] BITS_CAP = (SPAN_LOG < 8) ? 4'(SPAN_LOG) : 4'd8;
    localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(CODE_LIMIT - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_BACK   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    function automatic logic [7:0] mask_sym(input logic [7:0] sym, input logic [3:0] bits);
        logic [8:0] m;
        m = (9'd1 << bits) - 9'd1;
        return sym & m[7:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [CODE_W-1:0] pfx,
                                                  input logic [7:0] sym);
        return SLOT_W'(pfx) * SLOT_W'(SYMBOL_SPAN) + SLOT_W'(sym);
    endfunction

    // dictionary memories
    logic [CODE_W-1:0] child_mem [SLOTS];
    logic [SLOT_W-1:0] back_mem  [CODE_LIMIT];

    t_state                  r_state, n_state;
    logic [3:0]              r_min_bits;
    logic [3:0]              r_img_bits, n_img_bits;
    logic                    r_in_image, n_in_image;
    logic [CODE_W-1:0]       r_prefix, n_prefix;
    logic [CODE_W-1:0]       r_free, n_free;
    logic [3:0]              r_cw, n_cw;

    logic                    r_in_valid;
    gif_lzw_pkg::t_in_item   r_in;
    gif_lzw_pkg::t_in_item   r_cur;
    logic [7:0]              r_cur_sym;
    logic [SLOT_W-1:0]       r_slot;
    logic [CODE_W-1:0]       r_child;

    logic [CODE_W-1:0]       r_rd_child;
    logic [SLOT_W-1:0]       r_rd_back;
    logic                    r_fwd;
    logic [CODE_W-1:0]       r_fwd_code;

    logic                    r_rec_valid;
    gif_lzw_pkg::t_emit_rec  r_rec;
    logic [7:0]              r_bit_buf;
    logic [2:0]              r_bit_fill;
    logic [63:0]             r_word;
    logic [3:0]              r_cnt;
    logic                    r_word_last;
    logic                    r_out_valid;
    gif_lzw_pkg::t_out_item  r_out;

    logic                    consume, in_take;
    logic                    rd1_en, rd2_en, wr_en;
    logic [SLOT_W-1:0]       rd1_addr;
    logic [CODE_W-1:0]       child_now;
    logic                    emit;
    gif_lzw_pkg::t_emit_rec  rec;
    logic                    rec_free, rec_take, word_free, drain;

    logic [7:0]              hd_sym;
    logic [CODE_W-1:0]       clear_code, first_code;
    logic [3:0]              st_bits;
    logic [CODE_W-1:0]       st_clear;
    logic [7:0]              st_sym;
    logic                    hit, grow, full;
    logic [CODE_W-1:0]       prefix_a;
    logic [3:0]              cw_grown, cw_a;
    logic [2:0]              k;

    logic [5:0]              off [4];
    logic [5:0]              total;
    logic [63:0]             acc;
    logic [3:0]              nbytes;
    logic [7:0]              nx_buf;
    logic [2:0]              nx_fill;
    logic [12:0]             cmask;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gif_lzw_pkg::CFG_IDX_MIN_BITS) ? {28'd0, r_min_bits} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bits <= gif_lzw_pkg::MIN_BITS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == gif_lzw_pkg::CFG_IDX_MIN_BITS) begin
            r_min_bits <= pwdata[3:0];
        end
    end

    // clamp minimum code size to at least 2 and to what the symbol span allows
    always_comb begin
        st_bits = r_min_bits;
        if (st_bits < 4'd2) begin
            st_bits = 4'd2;
        end
        if (st_bits > BITS_CAP) begin
            st_bits = BITS_CAP;
        end
    end

    assign st_clear   = CODE_W'(1) << st_bits;
    assign st_sym     = mask_sym(r_in.symbol, st_bits);
    assign hd_sym     = mask_sym(r_in.symbol, r_img_bits);
    assign clear_code = CODE_W'(1) << r_img_bits;
    assign first_code = clear_code + CODE_W'(2);
    assign child_now  = r_fwd ? r_fwd_code : r_rd_child;

    // ---------------- dictionary decision ----------------
    always_comb begin
        if (r_child >= first_code && r_child < r_free && r_rd_back == r_slot) begin
            hit = 1'b1;
        end else begin
            hit = 1'b0;
        end
    end

    assign grow     = (r_cw < 4'(MAX_CODE_BITS)) && (16'(r_free) == (16'd1 << r_cw));
    assign full     = r_free >= LAST_CODE;
    assign cw_grown = r_cw + 4'(grow);
    assign cw_a     = hit ? r_cw : (full ? r_img_bits + 4'd1 : cw_grown);
    assign prefix_a = hit ? r_child : CODE_W'(r_cur_sym);

    always_comb begin
        n_state    = r_state;
        n_prefix   = r_prefix;
        n_free     = r_free;
        n_cw       = r_cw;
        n_img_bits = r_img_bits;
        n_in_image = r_in_image;
        consume    = 1'b0;
        rd1_en     = 1'b0;
        rd1_addr   = slot_of(r_prefix, hd_sym);
        rd2_en     = 1'b0;
        wr_en      = 1'b0;
        emit       = 1'b0;
        rec        = '0;
        k          = 3'd0;
        unique case (r_state)
            S_IDLE: begin
                if (r_in_valid) begin
                    if (!r_in_image) begin
                        if (rec_free) begin
                            // image start: size byte then clear code; a one-symbol image also ends here
                            consume    = 1'b1;
                            emit       = 1'b1;
                            rec.start  = 1'b1;
                            rec.slots[0].code  = 12'(st_bits);
                            rec.slots[0].width = 4'd8;
                            rec.slots[1].code  = 12'(st_clear);
                            rec.slots[1].width = st_bits + 4'd1;
                            n_img_bits = st_bits;
                            n_cw       = st_bits + 4'd1;
                            n_free     = st_clear + CODE_W'(2);
                            n_prefix   = CODE_W'(st_sym);
                            n_in_image = 1'b1;
                            if (r_in.image_end) begin
                                rec.last           = 1'b1;
                                rec.slots[2].code  = 12'(st_sym);
                                rec.slots[2].width = st_bits + 4'd1;
                                rec.slots[3].code  = 12'(st_clear + CODE_W'(1));
                                rec.slots[3].width = st_bits + 4'd1;
                                n_in_image         = 1'b0;
                            end
                        end
                    end else begin
                        consume = 1'b1;
                        rd1_en  = 1'b1;
                        n_state = S_BACK;
                    end
                end
            end
            S_BACK: begin
                rd2_en  = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (rec_free) begin
                    rec.last = r_cur.image_end;
                    n_prefix = prefix_a;
                    n_cw     = cw_a;
                    if (!hit) begin
                        wr_en = 1'b1;
                        rec.slots[k[1:0]].code  = 12'(r_prefix);
                        rec.slots[k[1:0]].width = r_cw;
                        k      = k + 3'd1;
                        n_free = r_free + CODE_W'(1);
                        if (full) begin
                            rec.slots[k[1:0]].code  = 12'(clear_code);
                            rec.slots[k[1:0]].width = cw_grown;
                            k      = k + 3'd1;
                            n_free = first_code;
                        end
                    end
                    if (r_cur.image_end) begin
                        rec.slots[k[1:0]].code  = 12'(prefix_a);
                        rec.slots[k[1:0]].width = cw_a;
                        k = k + 3'd1;
                        rec.slots[k[1:0]].code  = 12'(clear_code + CODE_W'(1));
                        rec.slots[k[1:0]].width = cw_a;
                        n_in_image = 1'b0;
                    end
                    emit = !hit || r_cur.image_end;
                    if (r_in_valid && !r_cur.image_end) begin
                        consume  = 1'b1;
                        rd1_en   = 1'b1;
                        rd1_addr = slot_of(prefix_a, hd_sym);
                        n_state  = S_BACK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- input register ----------------
    assign o_in_stall = r_in_valid && !consume;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (consume) begin
            r_cur     <= r_in;
            r_cur_sym <= hd_sym;
            r_slot    <= rd1_addr;
        end
        if (r_state == S_BACK) begin
            r_child <= child_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prefix   <= '0;
            r_free     <= CODE_W'(258);
            r_cw       <= 4'd9;
            r_img_bits <= gif_lzw_pkg::MIN_BITS_RESET;
            r_in_image <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prefix   <= n_prefix;
            r_free     <= n_free;
            r_cw       <= n_cw;
            r_img_bits <= n_img_bits;
            r_in_image <= n_in_image;
            // read and write of one entry in one cycle: the read sees old data
            r_fwd      <= rd1_en && wr_en && (rd1_addr == r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_code <= r_free;
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            child_mem[r_slot] <= r_free;
        end
        if (rd1_en) begin
            r_rd_child <= child_mem[rd1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            back_mem[r_free] <= r_slot;
        end
        if (rd2_en) begin
            r_rd_back <= back_mem[child_now];
        end
    end

    // ---------------- record register ----------------
    assign drain     = (r_cnt != 4'd0) && (!r_out_valid || !i_out_stall);
    assign word_free = (r_cnt == 4'd0) || (r_cnt == 4'd1 && drain);
    assign rec_take  = r_rec_valid && word_free;
    assign rec_free  = !r_rec_valid || rec_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_valid <= 1'b0;
        end else if (emit) begin
            r_rec_valid <= 1'b1;
        end else if (rec_take) begin
            r_rec_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rec <= rec;
        end
    end

    // ---------------- bit packer ----------------
    always_comb begin
        off[0] = r_rec.start ? 6'd0 : 6'(r_bit_fill);
        acc    = r_rec.start ? 64'd0 : 64'(r_bit_buf);
        for (int i = 0; i < 4; i++) begin
            cmask = (13'd1 << r_rec.slots[i].width) - 13'd1;
            acc   = acc | (64'(r_rec.slots[i].code & cmask[11:0]) << off[i]);
            if (i < 3) begin
                off[i+1] = off[i] + 6'(r_rec.slots[i].width);
            end
        end
        total = off[3] + 6'(r_rec.slots[3].width);
        if (r_rec.last) begin
            nbytes  = 4'(total[5:3]) + 4'(total[2:0] != 3'd0);
            nx_buf  = 8'd0;
            nx_fill = 3'd0;
        end else begin
            nbytes  = 4'(total[5:3]);
            nx_buf  = 8'(acc >> {total[5:3], 3'b000});
            nx_fill = total[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 4'd0;
            r_bit_buf  <= 8'd0;
            r_bit_fill <= 3'd0;
        end else begin
            if (drain) begin
                r_cnt <= r_cnt - 4'd1;
            end
            if (rec_take) begin
                r_cnt      <= nbytes;
                r_bit_buf  <= nx_buf;
                r_bit_fill <= nx_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_word <= r_word >> 8;
        end
        if (rec_take) begin
            r_word      <= acc;
            r_word_last <= r_rec.last;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (drain) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out.out_byte    <= r_word[7:0];
            r_out.stream_done <= r_word_last && (r_cnt == 4'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/gif_lzw_chk.sv
module gif_lzw_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input gif_lzw_pkg::t_out_item o_out_data
);

    logic r_first_byte;

    // next byte out opens a new stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_byte <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            r_first_byte <= o_out_data.stream_done;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake active right after reset");

    a_size_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && r_first_byte |->
            o_out_data.out_byte >= 8'd2 && o_out_data.out_byte <= 8'd8 &&
            !o_out_data.stream_done)
        else $error("stream does not open with a minimum code size byte");

endmodule

bind gif_lzw_code_stream_encoder_unit gif_lzw_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
